@@ sv/seven_segment_text_encoder_defines.svh @@
// Assertion macros for the seven-segment text encoder.
// Used by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_TEXT_ENCODER_DEFINES_SVH
`define SEVEN_SEGMENT_TEXT_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define SSENC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSENC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSENC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ssenc_pkg.sv @@
// Shared types, character codes and glyph tables for the seven-segment
// text encoder. No dependencies.
package ssenc_pkg;

    localparam int OUT_DIGITS = 4;

    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_DOT      = 8'h2e;
    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI = 8'h7a;

    localparam logic [7:0] DP_MASK     = 8'h10;
    localparam logic [7:0] BLANK_GLYPH = 8'h00;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'he7, 8'h06, 8'hcb, 8'h8f, 8'h2e, 8'had, 8'hed, 8'h86, 8'hef, 8'hae
    };

    localparam logic [7:0] LETTER_GLYPH [26] = '{
        8'hee, 8'h6d, 8'he1, 8'h4f, 8'he9, 8'he8, 8'haf, 8'h6c, 8'h60, 8'h47,
        8'h00, 8'h61, 8'h00, 8'he6, 8'he7, 8'hea, 8'hae, 8'he2, 8'had, 8'h69,
        8'h67, 8'h00, 8'h00, 8'h00, 8'h2f, 8'hcb
    };

    typedef struct packed {
        logic       is_dot;
        logic       ok;
        logic [7:0] pattern;
    } t_glyph;

    typedef struct packed {
        logic                       status;
        logic [OUT_DIGITS-1:0][7:0] digits;
    } t_result;

endpackage

@@ sv/seven_segment_text_encoder.sv @@
// Top level of the seven-segment text encoder.
// Depends on ssenc_pkg, ssenc_glyph, ssenc_assemble, ssenc_out_buf and
// seven_segment_text_encoder_defines.svh.
//
// Input channel: one text byte per transfer (i_in_valid / o_in_stall).
// A zero byte ends the string; other bytes update a string not yet rejected
// and give no result. Output channel (o_out_valid / i_out_stall): one
// result per zero byte with a status bit (0 shown, 1 rejected) and the
// four digit patterns, digit 0 rightmost, bit 4 the decimal point. On a
// rejected string the previously shown patterns are repeated.
// A zero byte's result is registered, or held in the skid entry on a stall.
// Throughput: one byte per cycle while o_in_stall is low; the byte is
// classified by a table lookup and folded into the state in the same cycle.
// When the receiver stalls, the result register holds and one more result
// goes into a skid entry; o_in_stall rises only while that entry is full.
// Reset clears the string state, the shown patterns and both output
// entries; the pattern store needs no clearing.
`include "seven_segment_text_encoder_defines.svh"
module seven_segment_text_encoder import ssenc_pkg::*; #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_out_status,
    output logic [7:0] o_out_digit0_segments,
    output logic [7:0] o_out_digit1_segments,
    output logic [7:0] o_out_digit2_segments,
    output logic [7:0] o_out_digit3_segments
);

    logic    in_accept;
    logic    res_valid;
    t_glyph  glyph;
    t_result result;
    t_result out_res;

    assign in_accept = i_in_valid && !o_in_stall;
    assign res_valid = in_accept && (i_in_char_code == CHAR_NUL);

    ssenc_glyph u_glyph (
        .i_char  (i_in_char_code),
        .o_glyph (glyph)
    );

    ssenc_assemble #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_assemble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_in_char_code),
        .i_glyph  (glyph),
        .o_result (result)
    );

    ssenc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out_res),
        .o_in_stall  (o_in_stall)
    );

    assign o_out_status          = out_res.status;
    assign o_out_digit0_segments = out_res.digits[0];
    assign o_out_digit1_segments = out_res.digits[1];
    assign o_out_digit2_segments = out_res.digits[2];
    assign o_out_digit3_segments = out_res.digits[3];

    `SSENC_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, o_in_stall, o_out_valid)
    `SSENC_ASSERT_NEXT(a_term_gives_result, i_clk, i_rst_n, res_valid, o_out_valid)
    `SSENC_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, o_in_stall && i_out_stall, o_in_stall)

endmodule

@@ sv/ssenc_glyph.sv @@
// Character classifier and segment lookup for one text byte.
// Depends on ssenc_pkg.
module ssenc_glyph import ssenc_pkg::*; (
    input  logic [7:0] i_char,
    output t_glyph     o_glyph
);

    logic [7:0] digit_off;
    logic [7:0] lower_off;
    logic [7:0] upper_off;

    assign digit_off = i_char - CHAR_DIGIT_LO;
    assign lower_off = i_char - CHAR_LOWER_LO;
    assign upper_off = i_char - CHAR_UPPER_LO;

    always_comb begin
        o_glyph = '{is_dot: 1'b0, ok: 1'b0, pattern: BLANK_GLYPH};
        case (i_char) inside
            CHAR_DOT: begin
                o_glyph.is_dot = 1'b1;
            end
            CHAR_SPACE: begin
                o_glyph.ok = 1'b1;
            end
            [CHAR_DIGIT_LO:CHAR_DIGIT_HI]: begin
                o_glyph.ok      = 1'b1;
                o_glyph.pattern = DIGIT_GLYPH[digit_off[3:0]];
            end
            [CHAR_LOWER_LO:CHAR_LOWER_HI]: begin
                o_glyph.pattern = LETTER_GLYPH[lower_off[4:0]];
                o_glyph.ok      = (o_glyph.pattern != BLANK_GLYPH);
            end
            [CHAR_UPPER_LO:CHAR_UPPER_HI]: begin
                o_glyph.pattern = LETTER_GLYPH[upper_off[4:0]];
                o_glyph.ok      = (o_glyph.pattern != BLANK_GLYPH);
            end
            default: begin
                o_glyph.ok = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/ssenc_assemble.sv @@
// String state: digit count, held character, per-string pattern store and
// the latched display. Depends on ssenc_pkg.
module ssenc_assemble import ssenc_pkg::*; #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  t_glyph     i_glyph,
    output t_result    o_result
);

    localparam int CW = $clog2(DIGIT_COUNT + 1);
    localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic [CW-1:0] r_done,     n_done;
    logic          r_open,     n_open;
    logic [7:0]    r_open_pat, n_open_pat;
    logic          r_bad,      n_bad;
    logic [7:0]    r_work  [DIGIT_COUNT];
    logic [7:0]    r_shown [DIGIT_COUNT];

    logic          is_term;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic [CW-1:0] done_c;
    logic          str_ok;
    logic [7:0]    work_next  [DIGIT_COUNT];
    logic [7:0]    shown_next [DIGIT_COUNT];

    assign is_term = (i_char == CHAR_NUL);
    assign wr_en   = i_accept && !r_bad && r_open;
    assign wr_data = r_open_pat | (i_glyph.is_dot ? DP_MASK : BLANK_GLYPH);
    assign done_c  = r_done + CW'(wr_en);
    assign str_ok  = !r_bad && (done_c == CW'(DIGIT_COUNT));

    always_comb begin
        n_done     = r_done;
        n_open     = r_open;
        n_open_pat = r_open_pat;
        n_bad      = r_bad;
        if (i_accept) begin
            if (is_term) begin
                n_done     = '0;
                n_open     = 1'b0;
                n_open_pat = BLANK_GLYPH;
                n_bad      = 1'b0;
            end else if (!r_bad) begin
                n_done = done_c;
                n_open = 1'b0;
                if (i_glyph.is_dot) begin
                    n_bad = !r_open;
                end else if (done_c >= CW'(DIGIT_COUNT)) begin
                    n_bad = 1'b1;
                end else if (!i_glyph.ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_open_pat = i_glyph.pattern;
                    n_open     = 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_work
        assign work_next[i] = (wr_en && r_done[IW-1:0] == IW'(i)) ? wr_data : r_work[i];
        assign shown_next[i] = work_next[DIGIT_COUNT-1-i];
    end

    assign o_result.status = !str_ok;
    for (genvar k = 0; k < OUT_DIGITS; k++) begin : g_out
        if (k < DIGIT_COUNT) begin : g_used
            assign o_result.digits[k] = str_ok ? shown_next[k] : r_shown[k];
        end else begin : g_unused
            assign o_result.digits[k] = BLANK_GLYPH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_open     <= 1'b0;
            r_open_pat <= BLANK_GLYPH;
            r_bad      <= 1'b0;
        end else begin
            r_done     <= n_done;
            r_open     <= n_open;
            r_open_pat <= n_open_pat;
            r_bad      <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_work[r_done[IW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_shown[i] <= BLANK_GLYPH;
            end
        end else if (i_accept && is_term && str_ok) begin
            r_shown <= shown_next;
        end
    end

endmodule

@@ sv/ssenc_out_buf.sv @@
// Result register with one skid entry between the string logic and the
// output channel. Depends on ssenc_pkg.
module ssenc_out_buf import ssenc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_out,
    output logic    o_in_stall
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    drain;

    assign drain       = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_in_stall  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

@@ dv/tb_seven_segment_text_encoder.sv @@
// Self-checking testbench for seven_segment_text_encoder: streams text bytes
// through the valid/stall channels and checks each result against an inline
// predictor. Depends on ssenc_pkg and the encoder RTL only.
module tb_seven_segment_text_encoder;
    import ssenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS      = 4;
    localparam int POS_MAX     = 8;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [7:0] HIGH_BYTE = 8'h80;

    localparam logic [7:0] NUM_SEG [10] = '{
        8'he7, 8'h06, 8'hcb, 8'h8f, 8'h2e, 8'had, 8'hed, 8'h86, 8'hef, 8'hae
    };
    localparam logic [7:0] ALPHA_SEG [26] = '{
        8'hee, 8'h6d, 8'he1, 8'h4f, 8'he9, 8'he8, 8'haf, 8'h6c, 8'h60, 8'h47,
        8'h00, 8'h61, 8'h00, 8'he6, 8'he7, 8'hea, 8'hae, 8'he2, 8'had, 8'h69,
        8'h67, 8'h00, 8'h00, 8'h00, 8'h2f, 8'hcb
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_char_code = CHAR_NUL;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_out_status;
    logic [7:0] o_out_digit0_segments;
    logic [7:0] o_out_digit1_segments;
    logic [7:0] o_out_digit2_segments;
    logic [7:0] o_out_digit3_segments;

    seven_segment_text_encoder #(.DIGIT_COUNT(DIGITS)) u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_char_code        (i_in_char_code),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_status          (o_out_status),
        .o_out_digit0_segments (o_out_digit0_segments),
        .o_out_digit1_segments (o_out_digit1_segments),
        .o_out_digit2_segments (o_out_digit2_segments),
        .o_out_digit3_segments (o_out_digit3_segments)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] pending_chars [$];
    t_result    expected_displays [$];
    logic [7:0] displayable_chars [$];
    logic [7:0] blocked_letters [$];

    int  total_chars;
    int  accepted_chars;
    int  fail_count;
    int  idle_cycles;
    int  hold_left;
    bit  char_taken;
    bit  pressure_done;

    // string state of the predictor
    int unsigned positions;
    bit          char_held;
    logic [7:0]  held_seg;
    bit          string_bad;
    logic [7:0]  text_seg [POS_MAX];
    logic [7:0]  lit_seg [DIGITS];

    function automatic t_glyph classify_char(logic [7:0] c);
        t_glyph g;
        g.is_dot  = (c == CHAR_DOT);
        g.ok      = 1'b1;
        g.pattern = BLANK_GLYPH;
        if (c == CHAR_SPACE) begin
            g.pattern = BLANK_GLYPH;
        end else if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
            g.pattern = NUM_SEG[c - CHAR_DIGIT_LO];
        end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
            g.pattern = ALPHA_SEG[c - CHAR_LOWER_LO];
            g.ok = (g.pattern != BLANK_GLYPH);
        end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
            g.pattern = ALPHA_SEG[c - CHAR_UPPER_LO];
            g.ok = (g.pattern != BLANK_GLYPH);
        end else begin
            g.ok = 1'b0;
        end
        return g;
    endfunction

    function automatic void close_position();
        if (!char_held)
            return;
        if (positions < POS_MAX)
            text_seg[positions] = held_seg;
        positions++;
        char_held = 1'b0;
    endfunction

    function automatic void encode_char(logic [7:0] c);
        t_glyph  g;
        t_result r;
        bit      shown;
        if (c != CHAR_NUL) begin
            if (string_bad)
                return;
            if (c == CHAR_DOT) begin
                if (char_held) begin
                    held_seg = held_seg | DP_MASK;
                    close_position();
                end else begin
                    string_bad = 1'b1;
                end
                return;
            end
            close_position();
            if (positions >= DIGITS) begin
                string_bad = 1'b1;
                return;
            end
            g = classify_char(c);
            if (!g.ok) begin
                string_bad = 1'b1;
                return;
            end
            held_seg  = g.pattern;
            char_held = 1'b1;
            return;
        end
        if (!string_bad)
            close_position();
        shown = !string_bad && positions == DIGITS;
        if (shown) begin
            for (int k = 0; k < DIGITS; k++)
                lit_seg[k] = text_seg[DIGITS - 1 - k];
        end
        r.status = !shown;
        for (int k = 0; k < DIGITS; k++)
            r.digits[k] = lit_seg[k];
        expected_displays.push_back(r);
        positions  = 0;
        char_held  = 1'b0;
        held_seg   = BLANK_GLYPH;
        string_bad = 1'b0;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(s[i]);
        pending_chars.push_back(CHAR_NUL);
    endfunction

    function automatic logic [7:0] pick(ref logic [7:0] pool [$]);
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic void add_random_string(bit well_formed);
        int n;
        int kind;
        n = well_formed ? DIGITS : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            kind = well_formed ? 0 : $urandom_range(0, 9);
            case (kind)
                6: pending_chars.push_back(8'($urandom_range(1, 255)));
                7: pending_chars.push_back(CHAR_DOT);
                8: pending_chars.push_back(pick(blocked_letters));
                9: pending_chars.push_back(CHAR_SPACE);
                default: pending_chars.push_back(pick(displayable_chars));
            endcase
            if ($urandom_range(0, 2) == 0)
                pending_chars.push_back(CHAR_DOT);
        end
        pending_chars.push_back(CHAR_NUL);
    endfunction

    function automatic int send_idle_pct();
        if (accepted_chars < total_chars / 3)
            return 24;
        if (accepted_chars < 2 * total_chars / 3)
            return 65;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_chars < total_chars / 3)
            return 65;
        if (accepted_chars < 2 * total_chars / 3)
            return 24;
        return 0;
    endfunction

    initial begin
        t_glyph g;
        positions  = 0;
        char_held  = 1'b0;
        held_seg   = BLANK_GLYPH;
        string_bad = 1'b0;
        for (int k = 0; k < DIGITS; k++)
            lit_seg[k] = BLANK_GLYPH;
        for (int c = 1; c < 256; c++) begin
            g = classify_char(8'(c));
            if (g.ok)
                displayable_chars.push_back(8'(c));
            else if ((c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI)
                     || (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI))
                blocked_letters.push_back(8'(c));
        end

        add_text(".");
        add_text("");
        add_text("8.8.8.8.");
        add_text("12345");
        pending_chars.push_back("k");
        pending_chars.push_back(HIGH_BYTE);
        pending_chars.push_back(CHAR_NUL);
        add_text("9 z");
        while (pending_chars.size() < 1800)
            add_random_string($urandom_range(0, 99) < 80);
        total_chars = pending_chars.size();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_chars.size() != 0 || expected_displays.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // driver: hold the offered byte until its transfer, then advance
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || char_taken)) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                i_in_valid     <= 1'b1;
                i_in_char_code <= pending_chars[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!pressure_done && i_rst_n && accepted_chars >= 3 * total_chars / 4) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
        end
    end

    // monitor: predict on each byte transfer, check each result transfer
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        bit      moved;
        moved = 1'b0;
        char_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                encode_char(i_in_char_code);
                void'(pending_chars.pop_front());
                accepted_chars++;
                char_taken = 1'b1;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got.status    = o_out_status;
                got.digits[0] = o_out_digit0_segments;
                got.digits[1] = o_out_digit1_segments;
                got.digits[2] = o_out_digit2_segments;
                got.digits[3] = o_out_digit3_segments;
                if (expected_displays.size() == 0) begin
                    $error("result transfer with no string terminated");
                    fail_count++;
                end else begin
                    want = expected_displays.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    for (int k = 0; k < DIGITS; k++) begin
                        if (got.digits[k] !== want.digits[k]) begin
                            $error("digit%0d_segments: expected %02h, actual %02h",
                                   k, want.digits[k], got.digits[k]);
                            fail_count++;
                        end
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
